// ----- hw/rtl/fbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types and codes for the binary frame parser with Fletcher-8 check.
// ----------------------------------------------------------------------------
package fbp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_ONE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_TWO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAV_CLASS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAV_ID     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  SYNC_ONE_RST   = 8'd181;
    localparam logic [7:0]  SYNC_TWO_RST   = 8'd98;
    localparam logic [7:0]  NAV_CLASS_RST  = 8'd1;
    localparam logic [7:0]  NAV_ID_RST     = 8'd0;
    localparam logic [15:0] MAX_LENGTH_RST = 16'd64;

    // Parser step codes.
    localparam logic [3:0] STEP_IDLE    = 4'd0;
    localparam logic [3:0] STEP_SYNC2   = 4'd1;
    localparam logic [3:0] STEP_CLASS   = 4'd2;
    localparam logic [3:0] STEP_ID      = 4'd3;
    localparam logic [3:0] STEP_LEN_LO  = 4'd4;
    localparam logic [3:0] STEP_LEN_HI  = 4'd5;
    localparam logic [3:0] STEP_PAYLOAD = 4'd6;
    localparam logic [3:0] STEP_CK_A    = 4'd7;
    localparam logic [3:0] STEP_CK_B    = 4'd8;

    // Frame status codes.
    localparam logic [2:0] STATUS_NONE    = 3'd0;
    localparam logic [2:0] STATUS_GOOD    = 3'd1;
    localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
    localparam logic [2:0] STATUS_CK_A_BAD = 3'd3;
    localparam logic [2:0] STATUS_CK_B_BAD = 3'd4;

    typedef struct packed {
        logic [7:0]  sync_one;
        logic [7:0]  sync_two;
        logic [7:0]  nav_class;
        logic [7:0]  nav_id;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  step;
        logic [7:0]  class_id;
        logic [7:0]  msg_id;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [15:0] length;
        logic [15:0] count;
    } parse_state_t;

    typedef struct packed {
        logic        payload_valid;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic [2:0]  frame_status;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic        nav_match;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fbp_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbp_step
// Next-state and result logic of the parser for one received byte.
// ----------------------------------------------------------------------------
module fbp_step (
    input  wire fbp_pkg::parse_state_t cur,
    input  wire fbp_pkg::cfg_t         cfg,
    input  wire logic [7:0]            rx_byte,
    output fbp_pkg::parse_state_t      nxt,
    output fbp_pkg::result_t           res
);
    import fbp_pkg::*;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [3:0]  hunt_step;
    logic [15:0] length_full;
    logic [15:0] count_inc;

    // Fletcher-8 running sums with this byte folded in.
    assign sum_a_add   = cur.sum_a + rx_byte;
    assign sum_b_add   = cur.sum_b + sum_a_add;
    assign hunt_step   = (rx_byte == cfg.sync_one) ? STEP_SYNC2 : STEP_IDLE;
    assign length_full = {rx_byte, cur.length[7:0]};
    assign count_inc   = cur.count + 16'd1;

    always_comb begin
        nxt = cur;
        res = '0;
        case (cur.step)
            STEP_SYNC2: begin
                nxt.step = (rx_byte == cfg.sync_two) ? STEP_CLASS : hunt_step;
            end
            STEP_CLASS: begin
                nxt.class_id = rx_byte;
                nxt.sum_a    = rx_byte;
                nxt.sum_b    = rx_byte;
                nxt.step     = STEP_ID;
            end
            STEP_ID: begin
                nxt.msg_id = rx_byte;
                nxt.sum_a  = sum_a_add;
                nxt.sum_b  = sum_b_add;
                nxt.step   = STEP_LEN_LO;
            end
            STEP_LEN_LO: begin
                nxt.sum_a  = sum_a_add;
                nxt.sum_b  = sum_b_add;
                nxt.length = {8'd0, rx_byte};
                nxt.step   = STEP_LEN_HI;
            end
            STEP_LEN_HI: begin
                nxt.sum_a  = sum_a_add;
                nxt.sum_b  = sum_b_add;
                nxt.length = length_full;
                if (length_full > cfg.max_length) begin
                    res.frame_status = STATUS_TOO_LONG;
                    nxt.step         = hunt_step;
                end else begin
                    nxt.count = '0;
                    nxt.step  = (length_full == 16'd0) ? STEP_CK_A : STEP_PAYLOAD;
                end
            end
            STEP_PAYLOAD: begin
                nxt.sum_a         = sum_a_add;
                nxt.sum_b         = sum_b_add;
                res.payload_valid = 1'b1;
                res.payload_index = cur.count;
                res.payload_byte  = rx_byte;
                nxt.count         = count_inc;
                if (count_inc == cur.length) begin
                    nxt.step = STEP_CK_A;
                end
            end
            STEP_CK_A: begin
                if (rx_byte != cur.sum_a) begin
                    res.frame_status = STATUS_CK_A_BAD;
                    nxt.step         = hunt_step;
                end else begin
                    nxt.step = STEP_CK_B;
                end
            end
            STEP_CK_B: begin
                nxt.step = STEP_IDLE;
                if (rx_byte != cur.sum_b) begin
                    res.frame_status = STATUS_CK_B_BAD;
                end else begin
                    res.frame_status = STATUS_GOOD;
                    res.nav_match    = (cur.class_id == cfg.nav_class) &&
                                       (cur.msg_id == cfg.nav_id);
                end
            end
            default: begin
                nxt.step = hunt_step;
            end
        endcase
        res.frame_class  = nxt.class_id;
        res.frame_id     = nxt.msg_id;
        res.frame_length = nxt.length;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/binary_frame_parser_fletcher_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_frame_parser_fletcher_top
// Byte-stream frame parser: preamble, class, id, length, payload and a
// two-byte Fletcher-8 check, one word per received byte and one result word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_valid / s_ready     s_rx_byte
//  m_        out        m_valid / m_ready     payload, status, frame fields
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each accepted input word gives exactly one result word in the next cycle, and
// a new word can be taken every cycle while results drain; the per-word logic is the step
// decode, 8-bit checksum adds, and 16-bit length and payload count compares.
// A held result that is not taken stops intake; a result drained in the same
// cycle lets the next word in. Reset (synchronous, active low) returns the
// parser to preamble hunting and restores register defaults. Config is always ready.
// ----------------------------------------------------------------------------
module binary_frame_parser_fletcher_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [7:0]                    s_rx_byte,

    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_payload_valid,
    output      logic [15:0]                   m_payload_index,
    output      logic [7:0]                    m_payload_byte,
    output      logic [2:0]                    m_frame_status,
    output      logic [7:0]                    m_frame_class,
    output      logic [7:0]                    m_frame_id,
    output      logic [15:0]                   m_frame_length,
    output      logic                          m_nav_match,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [fbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fbp_pkg::*;

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      result_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    logic         accept;

    // Intake is open whenever the result slot is free or being emptied now.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration writes. Indexes beyond the register list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_ONE:   cfg_next.sync_one   = cfg_data[7:0];
                CFG_SYNC_TWO:   cfg_next.sync_two   = cfg_data[7:0];
                CFG_NAV_CLASS:  cfg_next.nav_class  = cfg_data[7:0];
                CFG_NAV_ID:     cfg_next.nav_id     = cfg_data[7:0];
                CFG_MAX_LENGTH: cfg_next.max_length = cfg_data[15:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    // The whole per-byte update of the frame tracker.
    parse_state_t step_state;
    result_t      step_result;

    fbp_step u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .rx_byte (s_rx_byte),
        .nxt     (step_state),
        .res     (step_result)
    );

    assign state_next   = accept ? step_state : state_reg;
    assign result_next  = accept ? step_result : result_reg;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_one   <= SYNC_ONE_RST;
            cfg_reg.sync_two   <= SYNC_TWO_RST;
            cfg_reg.nav_class  <= NAV_CLASS_RST;
            cfg_reg.nav_id     <= NAV_ID_RST;
            cfg_reg.max_length <= MAX_LENGTH_RST;
            state_reg          <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_valid = result_reg.payload_valid;
    assign m_payload_index = result_reg.payload_index;
    assign m_payload_byte  = result_reg.payload_byte;
    assign m_frame_status  = result_reg.frame_status;
    assign m_frame_class   = result_reg.frame_class;
    assign m_frame_id      = result_reg.frame_id;
    assign m_frame_length  = result_reg.frame_length;
    assign m_nav_match     = result_reg.nav_match;

`ifndef SYNTH
    // An accepted byte always yields a result word on the next cycle.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted byte produced no result");

    // A payload byte never carries a frame status.
    a_payload_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_valid) |-> (m_frame_status == STATUS_NONE))
        else $error("payload byte carries a frame status");

    // A navigation match is only reported on a good frame.
    a_match_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nav_match) |-> (m_frame_status == STATUS_GOOD))
        else $error("nav match without good status");

    // While in the payload, the byte count stays below the frame length.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.step == STEP_PAYLOAD) |-> (state_reg.count < state_reg.length))
        else $error("payload count out of range");

    // The tracker only moves on an accepted byte.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("parser state changed without input");
`endif

endmodule
`default_nettype wire
